/* src/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants for the command frame parser: result kinds,
// parse phases, configuration register indexes and per-module limit tables.
// ----------------------------------------------------------------------------
package cfp_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ARG    = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_ABORT  = 2'd3
  } kind_t;

  // Parse phases, one-hot
  typedef enum logic [6:0] {
    PH_HUNT     = 7'b0000001,
    PH_MODULE   = 7'b0000010,
    PH_FUNCTION = 7'b0000100,
    PH_COUNT    = 7'b0001000,
    PH_LENGTH   = 7'b0010000,
    PH_DATA     = 7'b0100000,
    PH_END      = 7'b1000000
  } phase_t;

  // Configuration register indexes
  localparam logic [1:0] REG_START_BYTE    = 2'd0;
  localparam logic [1:0] REG_END_BYTE      = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [7:0]  START_BYTE_RESET = 8'd255;
  localparam logic [7:0]  END_BYTE_RESET   = 8'd0;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd2000;
  localparam logic [16:0] IDLE_MAX         = 17'h1FFFF;

  // Per-module limits; modules past the listed ones have all limits zero
  localparam logic [7:0] FUNC_LIMIT [32] = '{
    8'd3, 8'd3, 8'd2, 8'd3, 8'd9, 8'd4, 8'd2, 8'd0, 8'd2, 8'd3, 8'd3, 8'd4,
    8'd6, 8'd5, 8'd3, 8'd5, 8'd5, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };
  localparam logic [7:0] COUNT_LIMIT [32] = '{
    8'd1, 8'd1, 8'd255, 8'd1, 8'd3, 8'd1, 8'd1, 8'd0, 8'd2, 8'd1, 8'd1, 8'd26,
    8'd2, 8'd1, 8'd1, 8'd10, 8'd10, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };
  localparam logic [7:0] LEN_LIMIT [32] = '{
    8'd5, 8'd2, 8'd255, 8'd32, 8'd4, 8'd2, 8'd1, 8'd0, 8'd4, 8'd2, 8'd1, 8'd3,
    8'd50, 8'd255, 8'd1, 8'd10, 8'd10, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  // Configuration register set
  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // One result item
  typedef struct packed {
    kind_t      kind;
    logic [4:0] module_num;
    logic [7:0] function_id;
    logic [7:0] arg_count;
    logic [7:0] arg_index;
    logic [7:0] byte_index;
    logic [7:0] arg_byte;
    logic       last_of_arg;
  } res_t;

endpackage

/* src/command_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// command_frame_parser_unit
// Deframes a length-prefixed command stream and streams out argument bytes
// and frame events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: a
//   received byte (command 0, rx_byte) or a millisecond tick (command 1).
//   Output channel (out_valid/out_ready) carries at most one result per
//   input item: an argument byte, frame complete, field rejected or frame
//   aborted, with the current frame's module, function, count and indexes.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_index
//   (0 start byte, 1 end byte, 2 timeout ticks) in the same cycle; write
//   only while no results are pending.
//   The parse step is combinational; results are registered at the output.
//   Throughput: one item per cycle while in_ready is high.
//   Reset clears the frame state to hunting, loads the register defaults
//   (start 255, end 0, timeout 2000) and empties the output stage.
//   When the receiver stalls, one further result is held in a skid entry;
//   in_ready then drops until the output register is taken.
// ----------------------------------------------------------------------------
module command_frame_parser_unit import cfp_pkg::*; #(
  parameter int NUM_MODULES = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [4:0]  module_num,
  output logic [7:0]  function_id,
  output logic [7:0]  arg_count,
  output logic [7:0]  arg_index,
  output logic [7:0]  byte_index,
  output logic [7:0]  arg_byte,
  output logic        last_of_arg
);

  cfg_t cfg;
  logic accept;
  logic res_valid;
  res_t res;
  res_t out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= START_BYTE_RESET;
      cfg.end_byte      <= END_BYTE_RESET;
      cfg.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_BYTE:    cfg.start_byte    <= cfg_data[7:0];
        REG_END_BYTE:      cfg.end_byte      <= cfg_data[7:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  cfp_step #(
    .NUM_MODULES (NUM_MODULES)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  cfp_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_res   (res),
    .can_accept (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  // Unpack result fields
  assign kind        = out_res.kind;
  assign module_num  = out_res.module_num;
  assign function_id = out_res.function_id;
  assign arg_count   = out_res.arg_count;
  assign arg_index   = out_res.arg_index;
  assign byte_index  = out_res.byte_index;
  assign arg_byte    = out_res.arg_byte;
  assign last_of_arg = out_res.last_of_arg;

endmodule

/* src/cfp_step.sv */
// ----------------------------------------------------------------------------
// cfp_step
// Frame state register and the combinational parse step: takes one byte or
// tick per accepted transfer and forms at most one result.
// ----------------------------------------------------------------------------
module cfp_step import cfp_pkg::*; #(
  parameter int NUM_MODULES = 18
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       command,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  phase_t      phase, phase_next;
  logic [4:0]  cur_module, cur_module_next;
  logic [7:0]  cur_function, cur_function_next;
  logic [7:0]  announced_args, announced_args_next;
  logic [7:0]  arg_counter, arg_counter_next;
  logic [7:0]  byte_counter, byte_counter_next;
  logic [7:0]  cur_arg_length, cur_arg_length_next;
  logic [16:0] idle_ticks, idle_ticks_next;

  logic [16:0] idle_inc;
  logic [8:0]  byte_count_inc;
  logic [7:0]  arg_count_inc;
  logic        data_last;

  // Derived counts
  assign idle_inc       = (idle_ticks < IDLE_MAX) ? idle_ticks + 17'd1 : idle_ticks;
  assign byte_count_inc = {1'b0, byte_counter} + 9'd1;
  assign arg_count_inc  = arg_counter + 8'd1;
  assign data_last      = (byte_count_inc >= {1'b0, cur_arg_length});

  // Parse step
  always_comb begin
    phase_next          = phase;
    cur_module_next     = cur_module;
    cur_function_next   = cur_function;
    announced_args_next = announced_args;
    arg_counter_next    = arg_counter;
    byte_counter_next   = byte_counter;
    cur_arg_length_next = cur_arg_length;
    idle_ticks_next     = idle_ticks;
    res_valid           = 1'b0;
    res.kind            = KIND_ARG;
    res.module_num      = cur_module;
    res.function_id     = cur_function;
    res.arg_count       = announced_args;
    res.arg_index       = arg_counter;
    res.byte_index      = byte_counter;
    res.arg_byte        = 8'd0;
    res.last_of_arg     = 1'b0;

    if (accept) begin
      if (command) begin
        // Tick: count idle time inside a frame, abort past the timeout
        if (phase != PH_HUNT) begin
          idle_ticks_next = idle_inc;
          if (idle_inc > {1'b0, cfg.timeout_ticks}) begin
            res_valid           = 1'b1;
            res.kind            = KIND_ABORT;
            phase_next          = PH_HUNT;
            arg_counter_next    = 8'd0;
            byte_counter_next   = 8'd0;
            cur_arg_length_next = 8'd0;
            idle_ticks_next     = 17'd0;
          end
        end
      end else begin
        idle_ticks_next = 17'd0;
        unique case (phase)
          PH_HUNT: begin
            if (rx_byte == cfg.start_byte) begin
              phase_next          = PH_MODULE;
              arg_counter_next    = 8'd0;
              byte_counter_next   = 8'd0;
              cur_arg_length_next = 8'd0;
            end
          end
          PH_MODULE: begin
            if ({1'b0, rx_byte} >= 9'(NUM_MODULES)) begin
              res_valid = 1'b1;
              res.kind  = KIND_REJECT;
            end else begin
              cur_module_next = rx_byte[4:0];
              phase_next      = PH_FUNCTION;
            end
          end
          PH_FUNCTION: begin
            if (rx_byte > FUNC_LIMIT[cur_module]) begin
              res_valid = 1'b1;
              res.kind  = KIND_REJECT;
            end else begin
              cur_function_next = rx_byte;
              phase_next        = PH_COUNT;
            end
          end
          PH_COUNT: begin
            if (rx_byte > COUNT_LIMIT[cur_module]) begin
              res_valid = 1'b1;
              res.kind  = KIND_REJECT;
            end else begin
              announced_args_next = rx_byte;
              arg_counter_next    = 8'd0;
              byte_counter_next   = 8'd0;
              phase_next          = (rx_byte == 8'd0) ? PH_END : PH_LENGTH;
            end
          end
          PH_LENGTH: begin
            // Zero length skips to the end wait; over-limit aborts
            if (rx_byte == 8'd0) begin
              phase_next = PH_END;
            end else if (rx_byte > LEN_LIMIT[cur_module]) begin
              res_valid           = 1'b1;
              res.kind            = KIND_ABORT;
              phase_next          = PH_HUNT;
              arg_counter_next    = 8'd0;
              byte_counter_next   = 8'd0;
              cur_arg_length_next = 8'd0;
            end else begin
              cur_arg_length_next = rx_byte;
              byte_counter_next   = 8'd0;
              phase_next          = PH_DATA;
            end
          end
          PH_DATA: begin
            res_valid       = 1'b1;
            res.kind        = KIND_ARG;
            res.arg_byte    = rx_byte;
            res.last_of_arg = data_last;
            if (data_last) begin
              byte_counter_next = 8'd0;
              arg_counter_next  = arg_count_inc;
              phase_next        = (arg_count_inc >= announced_args) ? PH_END : PH_LENGTH;
            end else begin
              byte_counter_next = byte_count_inc[7:0];
            end
          end
          PH_END: begin
            if (rx_byte == cfg.end_byte) begin
              res_valid           = 1'b1;
              res.kind            = KIND_DONE;
              phase_next          = PH_HUNT;
              arg_counter_next    = 8'd0;
              byte_counter_next   = 8'd0;
              cur_arg_length_next = 8'd0;
            end
          end
          default: begin
            phase_next          = PH_HUNT;
            arg_counter_next    = 8'd0;
            byte_counter_next   = 8'd0;
            cur_arg_length_next = 8'd0;
          end
        endcase
      end
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      cur_module     <= 5'd0;
      cur_function   <= 8'd0;
      announced_args <= 8'd0;
      arg_counter    <= 8'd0;
      byte_counter   <= 8'd0;
      cur_arg_length <= 8'd0;
      idle_ticks     <= 17'd0;
    end else begin
      phase          <= phase_next;
      cur_module     <= cur_module_next;
      cur_function   <= cur_function_next;
      announced_args <= announced_args_next;
      arg_counter    <= arg_counter_next;
      byte_counter   <= byte_counter_next;
      cur_arg_length <= cur_arg_length_next;
      idle_ticks     <= idle_ticks_next;
    end
  end

`ifndef SYNTHESIS
  a_arg_only_in_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_ARG |-> phase == PH_DATA)
    else $error("argument byte emitted outside the data phase");

  a_abort_to_hunt: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_ABORT |=> phase == PH_HUNT && idle_ticks == 17'd0)
    else $error("abort did not return to hunting");

  a_byte_clears_idle: assert property (@(posedge clk) disable iff (rst)
    accept && !command |=> idle_ticks == 17'd0)
    else $error("received byte did not clear idle count");

  a_tick_in_hunt: assert property (@(posedge clk) disable iff (rst)
    accept && command && phase == PH_HUNT |-> !res_valid ##1 phase == PH_HUNT)
    else $error("tick while hunting changed state or gave a result");
`endif

endmodule

/* src/cfp_out_buf.sv */
// ----------------------------------------------------------------------------
// cfp_out_buf
// Result register with one skid entry, so a new transfer is taken while a
// finished result still waits for the receiver.
// ----------------------------------------------------------------------------
module cfp_out_buf import cfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_res,
  output logic can_accept,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic skid_valid;
  res_t skid_res;
  logic pop;

  assign pop        = out_valid && out_ready;
  assign can_accept = !skid_valid;

  // Advance the skid entry or load a new result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_res <= push_res;
      end else begin
        skid_res <= push_res;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed with skid entry occupied");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && !skid_valid)
    else $error("skid entry not moved on after transfer");
`endif

endmodule
